// ===== hw/rtl/frdnt_pkg.sv =====
// Package for the flood relay duplicate cache and neighbor table block.
// Holds sizes, verdict codes, sequencer states and the table entry type.
// No dependencies.
package frdnt_pkg;

  localparam int DEDUP_DEPTH_DEF = 64;
  localparam int NODE_SLOTS_DEF  = 16;

  typedef enum logic [2:0] {
    VERDICT_OWN       = 3'd0,
    VERDICT_DUP       = 3'd1,
    VERDICT_NO_RELAY  = 3'd2,
    VERDICT_RELAY     = 3'd3,
    VERDICT_SLOT_READ = 3'd4
  } verdict_t;

  typedef enum logic [0:0] {
    CFG_OWN_ID  = 1'd0,
    CFG_TIMEOUT = 1'd1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DEDUP,
    ST_DEDUP_CHK,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        used;
    logic [15:0] ident;
    logic [47:0] addr;
    logic        direct;
    logic [7:0]  signal;
    logic [7:0]  hop_dist;
    logic [31:0] heard;
    logic [31:0] dtime;
  } entry_t;

  // Status from the sequencer to the output stage.
  typedef struct packed {
    logic        load;
    logic [2:0]  verdict;
    logic [7:0]  ttl;
    logic [7:0]  hops;
  } res_ctl_t;

endpackage

// ===== hw/rtl/flood_relay_dedup_neighbor_table.sv =====
// Top level: duplicate filter and neighbor table updater for a flooding mesh.
// Depends on frdnt_pkg, frdnt_dedup and frdnt_table.
//
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   packet header or slot read request
// out_      output     out_valid / out_ready verdict, relay fields, slot contents
// cfg_      input      cfg_we                cfg_index, cfg_data
//
// After reset a clearing pass sweeps both memories with in_ready low.
// A slot read reads the requested slot and an own packet goes straight to its result.
// A duplicate is found by a scan of the whole cache. A new packet takes the cache scan
// plus, for each touched node, a table scan; the origin is touched only when it differs
// from the sender. One transaction is in flight at a time; the next one can be accepted in
// the cycle after the result is taken, so a held result stalls the input.
module flood_relay_dedup_neighbor_table #(
  parameter int DEDUP_DEPTH = frdnt_pkg::DEDUP_DEPTH_DEF,
  parameter int NODE_SLOTS  = frdnt_pkg::NODE_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         in_req_type,
  input  logic [15:0]  in_origin_id,
  input  logic [15:0]  in_sequence_number,
  input  logic [7:0]   in_time_to_live,
  input  logic [7:0]   in_hop_count,
  input  logic [47:0]  in_sender_address,
  input  logic [47:0]  in_origin_address,
  input  logic signed [7:0] in_signal_strength,
  input  logic [31:0]  in_time_now_ms,
  input  logic [3:0]   in_slot_index,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [2:0]   out_verdict,
  output logic [7:0]   out_relay_ttl,
  output logic [7:0]   out_relay_hops,
  output logic         out_slot_used,
  output logic [15:0]  out_slot_node_id,
  output logic         out_slot_direct,
  output logic [7:0]   out_slot_hops,
  output logic signed [7:0] out_slot_signal,
  output logic [31:0]  out_slot_last_seen,
  output logic [31:0]  out_slot_last_direct,
  output logic [47:0]  out_slot_address
);
  import frdnt_pkg::*;

  localparam int DW = $clog2(DEDUP_DEPTH);
  localparam int SW = $clog2(NODE_SLOTS);
  localparam int CW = (DW > SW ? DW : SW) + 1;
  localparam logic [CW-1:0] DLAST = CW'(DEDUP_DEPTH - 1);
  localparam logic [CW-1:0] SLAST = CW'(NODE_SLOTS - 1);
  localparam logic [CW-1:0] CLAST = (DEDUP_DEPTH > NODE_SLOTS) ? DLAST : SLAST;
  localparam logic [DW-1:0] WLAST = DW'(DEDUP_DEPTH - 1);

  state_t state_r, state_nxt;
  logic [15:0] own_id_r;
  logic [31:0] timeout_r;

  // Captured request.
  logic        rq_read_r;
  logic [15:0] rq_origin_r, rq_seq_r;
  logic [7:0]  rq_ttl_r, rq_hops_r, rq_sig_r;
  logic [47:0] rq_saddr_r, rq_oaddr_r;
  logic [31:0] rq_now_r;
  logic [3:0]  rq_idx_r;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] wptr_r;
  logic          pass_r;    // 0 = sender pass, 1 = origin pass
  logic          found_r, free_r;
  logic [SW-1:0] hit_r, free_slot_r, old_r;
  logic [31:0]   old_time_r;
  logic          dup_r;

  // Dedup memory ports.
  logic          d_we;
  logic [DW-1:0] d_waddr, d_raddr;
  logic [32:0]   d_wdata, d_rdata;
  // Table memory ports.
  logic          t_we;
  logic [SW-1:0] t_waddr, t_raddr;
  entry_t        t_wdata, t_rdata;

  frdnt_dedup #(.DEPTH(DEDUP_DEPTH), .AW(DW)) u_dedup (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr), .rdata(d_rdata)
  );
  frdnt_table #(.SLOTS(NODE_SLOTS), .SW(SW)) u_table (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata)
  );

  // Per-pass node parameters.
  logic [15:0] node_id;
  logic [47:0] node_addr;
  assign node_id   = pass_r ? rq_origin_r : rq_saddr_r[15:0];
  assign node_addr = pass_r ? rq_oaddr_r : rq_saddr_r;

  // Shared compare unit: equality for cache keys, less-than for ages.
  logic [31:0] cmp_a, cmp_b;
  logic        cmp_eq, cmp_lt;
  assign cmp_eq = (cmp_a == cmp_b);
  assign cmp_lt = (cmp_a < cmp_b);
  always_comb begin
    if (state_r == ST_DEDUP || state_r == ST_DEDUP_CHK) begin
      cmp_a = d_rdata[31:0];
      cmp_b = {rq_origin_r, rq_seq_r};
    end else begin
      cmp_a = t_rdata.heard;
      cmp_b = old_time_r;
    end
  end
  logic id_hit;
  assign id_hit = t_rdata.used && (t_rdata.ident == node_id);

  logic accept;
  assign accept = in_valid && in_ready;

  // Scan read counter index as it was in the previous cycle, matching the registered read.
  logic [CW-1:0] prev;
  assign prev = cnt_r - CW'(1);

  // Chosen slot and updated entry.
  logic [SW-1:0] sel;
  logic          is_new;
  entry_t        base, upd;
  logic [31:0]   age;
  always_comb begin
    is_new = !found_r;
    sel    = found_r ? hit_r : (free_r ? free_slot_r : old_r);
    base   = t_rdata;
    if (is_new) begin
      base = '0;
      base.used     = 1'b1;
      base.ident    = node_id;
      base.hop_dist = pass_r ? rq_hops_r + 8'd1 : 8'd1;
    end
    upd       = base;
    upd.addr  = node_addr;
    upd.heard = rq_now_r;
    age       = rq_now_r - base.dtime;
    if (!pass_r) begin
      upd.direct   = 1'b1;
      upd.signal   = rq_sig_r;
      upd.hop_dist = 8'd1;
      upd.dtime    = rq_now_r;
    end else begin
      if (age > timeout_r) upd.direct = 1'b0;
      if (!upd.direct &&
          ((rq_hops_r + 8'd1) < base.hop_dist || base.hop_dist == 8'd0)) begin
        upd.hop_dist = rq_hops_r + 8'd1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (cnt_r == CLAST) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type) state_nxt = ST_UPDATE;
          else if (in_origin_id == own_id_r) state_nxt = ST_DONE;
          else state_nxt = ST_DEDUP;
        end
      end
      ST_DEDUP: if (cnt_r == DLAST) state_nxt = ST_DEDUP_CHK;
      ST_DEDUP_CHK: state_nxt = ST_SCAN;
      // The last count re-reads the chosen slot once the scan registers have settled.
      ST_SCAN: if (dup_r) state_nxt = ST_DONE;
               else if (cnt_r == SLAST + CW'(2)) state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        if (rq_read_r || pass_r || rq_origin_r == rq_saddr_r[15:0]) state_nxt = ST_DONE;
        else state_nxt = ST_SCAN;
      end
      ST_DONE: if (!out_valid || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    d_we    = 1'b0;
    d_waddr = wptr_r;
    d_wdata = {1'b1, rq_origin_r, rq_seq_r};
    d_raddr = cnt_r[DW-1:0];
    t_we    = 1'b0;
    t_waddr = sel;
    t_wdata = upd;
    t_raddr = cnt_r[SW-1:0];
    cnt_nxt = cnt_r + CW'(1);
    unique case (state_r)
      ST_CLEAR: begin
        d_we    = (cnt_r <= DLAST);
        d_waddr = cnt_r[DW-1:0];
        d_wdata = '0;
        if (cnt_r <= SLAST) begin
          t_we    = 1'b1;
          t_waddr = cnt_r[SW-1:0];
          t_wdata = '0;
        end
      end
      ST_IDLE: begin
        cnt_nxt = '0;
        t_raddr = SW'(in_slot_index);
      end
      ST_DEDUP_CHK: begin
        cnt_nxt = '0;
        d_we    = !(dup_r || (d_rdata[32] && cmp_eq));
      end
      ST_SCAN: begin
        if (cnt_r == SLAST + CW'(2)) t_raddr = sel;
      end
      ST_UPDATE: begin
        cnt_nxt = '0;
        t_we    = !rq_read_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      cnt_r     <= '0;
      own_id_r  <= '0;
      timeout_r <= 32'd10000;
      wptr_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_OWN_ID:  own_id_r  <= cfg_data[15:0];
          CFG_TIMEOUT: timeout_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_DEDUP_CHK && d_we) begin
        wptr_r <= (wptr_r == WLAST) ? '0 : wptr_r + DW'(1);
      end
      if (state_r == ST_DONE && state_nxt == ST_IDLE) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      rq_read_r   <= in_req_type;
      rq_origin_r <= in_origin_id;
      rq_seq_r    <= in_sequence_number;
      rq_ttl_r    <= in_time_to_live;
      rq_hops_r   <= in_hop_count;
      rq_saddr_r  <= in_sender_address;
      rq_oaddr_r  <= in_origin_address;
      rq_sig_r    <= in_signal_strength;
      rq_now_r    <= in_time_now_ms;
      rq_idx_r    <= in_slot_index;
      pass_r      <= 1'b0;
      dup_r       <= (in_origin_id == own_id_r) && !in_req_type;
    end
    // Data for address cnt-1 arrives while cnt is presented.
    if (state_r == ST_DEDUP && cnt_r != '0 && d_rdata[32] && cmp_eq) dup_r <= 1'b1;
    if (state_r == ST_DEDUP_CHK) begin
      if (d_rdata[32] && cmp_eq) dup_r <= 1'b1;
      found_r    <= 1'b0;
      free_r     <= 1'b0;
      old_r      <= '0;
      old_time_r <= '1;
    end
    if (state_r == ST_SCAN && cnt_r != '0 && cnt_r <= SLAST + CW'(1)) begin
      if (!found_r && id_hit) begin
        found_r <= 1'b1;
        hit_r   <= prev[SW-1:0];
      end
      if (!free_r && !t_rdata.used) begin
        free_r      <= 1'b1;
        free_slot_r <= prev[SW-1:0];
      end
      if (prev == '0 || cmp_lt) begin
        old_r      <= prev[SW-1:0];
        old_time_r <= t_rdata.heard;
      end
    end
    if (state_r == ST_UPDATE) begin
      pass_r     <= 1'b1;
      found_r    <= 1'b0;
      free_r     <= 1'b0;
      old_r      <= '0;
      old_time_r <= '1;
    end
    if (state_r == ST_UPDATE && rq_read_r) begin
      if (32'(rq_idx_r) >= 32'(NODE_SLOTS)) begin
        out_slot_used <= 1'b0; out_slot_node_id <= '0; out_slot_direct <= 1'b0;
        out_slot_hops <= '0; out_slot_signal <= '0; out_slot_last_seen <= '0;
        out_slot_last_direct <= '0; out_slot_address <= '0;
      end else begin
        out_slot_used       <= t_rdata.used;
        out_slot_node_id    <= t_rdata.ident;
        out_slot_direct     <= t_rdata.direct;
        out_slot_hops       <= t_rdata.hop_dist;
        out_slot_signal     <= t_rdata.signal;
        out_slot_last_seen  <= t_rdata.heard;
        out_slot_last_direct<= t_rdata.dtime;
        out_slot_address    <= t_rdata.addr;
      end
    end
    if (state_r == ST_DONE && state_nxt == ST_IDLE) begin
      if (rq_read_r) begin
        out_verdict    <= VERDICT_SLOT_READ;
        out_relay_ttl  <= '0;
        out_relay_hops <= '0;
      end else begin
        out_slot_used <= 1'b0; out_slot_node_id <= '0; out_slot_direct <= 1'b0;
        out_slot_hops <= '0; out_slot_signal <= '0; out_slot_last_seen <= '0;
        out_slot_last_direct <= '0; out_slot_address <= '0;
        if (rq_origin_r == own_id_r && !pass_r && dup_r && cnt_r == '0) begin
          out_verdict    <= VERDICT_OWN;
          out_relay_ttl  <= '0;
          out_relay_hops <= '0;
        end else if (dup_r) begin
          out_verdict    <= VERDICT_DUP;
          out_relay_ttl  <= '0;
          out_relay_hops <= '0;
        end else if (rq_ttl_r != 8'd0) begin
          out_verdict    <= VERDICT_RELAY;
          out_relay_ttl  <= rq_ttl_r - 8'd1;
          out_relay_hops <= rq_hops_r + 8'd1;
        end else begin
          out_verdict    <= VERDICT_NO_RELAY;
          out_relay_ttl  <= '0;
          out_relay_hops <= '0;
        end
      end
    end
  end

  assign in_ready = (state_r == ST_IDLE) && !out_valid;

endmodule

// ===== hw/rtl/frdnt_dedup.sv =====
// Duplicate cache ring memory with a registered read port.
// Depends on frdnt_pkg. Reset clearing is done by the sequencer with a sweep.
module frdnt_dedup #(
  parameter int DEPTH = frdnt_pkg::DEDUP_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [32:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [32:0]   rdata
);
  import frdnt_pkg::*;

  // Bit 32 marks an entry that holds a key stored since the reset sweep.
  logic [32:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/frdnt_table.sv =====
// Neighbor table memory: one entry per slot, read and written by address.
// Depends on frdnt_pkg.
module frdnt_table #(
  parameter int SLOTS = frdnt_pkg::NODE_SLOTS_DEF,
  parameter int SW    = $clog2(SLOTS)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [SW-1:0]   waddr,
  input  frdnt_pkg::entry_t wdata,
  input  logic [SW-1:0]   raddr,
  output frdnt_pkg::entry_t rdata
);
  import frdnt_pkg::*;

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/frdnt_checker.sv =====
// Port-level checker for the flood relay block, bound to the top level.
// Depends on frdnt_pkg.
module frdnt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_verdict,
  input logic [7:0] out_relay_ttl,
  input logic       out_slot_used
);
  import frdnt_pkg::*;

  a_no_accept_while_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while a result is held");

  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_verdict <= VERDICT_SLOT_READ) else $error("bad verdict");

  a_ttl_only_relay: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict != VERDICT_RELAY) |-> out_relay_ttl == 8'd0)
    else $error("relay ttl on a non-relay result");

  a_used_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict != VERDICT_SLOT_READ) |-> !out_slot_used)
    else $error("slot used flag on a packet result");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_verdict))
    else $error("result dropped while stalled");

endmodule

bind flood_relay_dedup_neighbor_table frdnt_checker u_frdnt_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_verdict, .out_relay_ttl, .out_slot_used
);

// ===== verif/tb_top.sv =====
// Testbench for the flood relay duplicate cache and neighbor table block.
// Drives packet and slot-read transactions and checks every result against an in-bench model.
// Depends on frdnt_pkg and flood_relay_dedup_neighbor_table.
`timescale 1ns / 1ps

module tb_top;
  import frdnt_pkg::*;

  localparam int CACHE_DEPTH = DEDUP_DEPTH_DEF;
  localparam int SLOTS = NODE_SLOTS_DEF;
  localparam int MAX_CYCLES = 1500000;

  typedef struct packed {
    logic        req_type;
    logic [15:0] origin_id;
    logic [15:0] seq;
    logic [7:0]  ttl;
    logic [7:0]  hops;
    logic [47:0] saddr;
    logic [47:0] oaddr;
    logic [7:0]  sig;
    logic [31:0] now;
    logic [3:0]  slot;
  } header_t;

  localparam int HDR_W = $bits(header_t);

  typedef struct packed {
    logic [2:0]  verdict;
    logic [7:0]  rttl;
    logic [7:0]  rhops;
    logic        used;
    logic [15:0] node_id;
    logic        direct;
    logic [7:0]  hop_dist;
    logic [7:0]  signal;
    logic [31:0] seen;
    logic [31:0] dseen;
    logic [47:0] addr;
  } verdict_rec_t;

  class relay_scoreboard;
    logic [15:0] own_id;
    logic [31:0] timeout_ms;
    logic [31:0] pair_cache[CACHE_DEPTH];
    bit          pair_ok[CACHE_DEPTH];
    int          wr_ptr;
    entry_t      tbl[SLOTS];
    verdict_rec_t pending[$];
    int          errors;
    int          results;

    function new();
      own_id = 16'd0;
      timeout_ms = 32'd10000;
      wr_ptr = 0;
      errors = 0;
      results = 0;
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        pair_cache[i] = '0;
        pair_ok[i] = 0;
      end
      for (int i = 0; i < SLOTS; i++) tbl[i] = '0;
    endfunction

    function void touch(logic [15:0] id, logic [47:0] addr, bit is_direct,
                        logic [7:0] sig, logic [7:0] hops, logic [31:0] now);
      int s;
      s = -1;
      for (int i = 0; i < SLOTS; i++)
        if (s < 0 && tbl[i].used && tbl[i].ident == id) s = i;
      if (s < 0) begin
        for (int i = 0; i < SLOTS; i++)
          if (s < 0 && !tbl[i].used) s = i;
        if (s < 0) begin
          s = 0;
          for (int i = 1; i < SLOTS; i++)
            if (tbl[i].heard < tbl[s].heard) s = i;
        end
        tbl[s] = '0;
        tbl[s].used = 1'b1;
        tbl[s].ident = id;
        tbl[s].hop_dist = hops;
      end
      tbl[s].addr = addr;
      tbl[s].heard = now;
      if (is_direct) begin
        tbl[s].direct = 1'b1;
        tbl[s].signal = sig;
        tbl[s].hop_dist = 8'd1;
        tbl[s].dtime = now;
      end else begin
        if (32'(now - tbl[s].dtime) > timeout_ms) tbl[s].direct = 1'b0;
        if (!tbl[s].direct && (hops < tbl[s].hop_dist || tbl[s].hop_dist == 8'd0))
          tbl[s].hop_dist = hops;
      end
    endfunction

    function void note_header(header_t h);
      verdict_rec_t r;
      logic [31:0] key;
      bit dup;
      r = '0;
      key = {h.origin_id, h.seq};
      dup = 0;
      if (h.req_type) begin
        r.verdict = VERDICT_SLOT_READ;
        r.used = tbl[h.slot].used;
        r.node_id = tbl[h.slot].ident;
        r.direct = tbl[h.slot].direct;
        r.hop_dist = tbl[h.slot].hop_dist;
        r.signal = tbl[h.slot].signal;
        r.seen = tbl[h.slot].heard;
        r.dseen = tbl[h.slot].dtime;
        r.addr = tbl[h.slot].addr;
      end else if (h.origin_id == own_id) begin
        r.verdict = VERDICT_OWN;
      end else begin
        for (int i = 0; i < CACHE_DEPTH; i++)
          if (pair_ok[i] && pair_cache[i] == key) dup = 1;
        if (dup) begin
          r.verdict = VERDICT_DUP;
        end else begin
          pair_cache[wr_ptr] = key;
          pair_ok[wr_ptr] = 1;
          wr_ptr = (wr_ptr + 1) % CACHE_DEPTH;
          touch(h.saddr[15:0], h.saddr, 1, h.sig, 8'd1, h.now);
          if (h.origin_id != h.saddr[15:0])
            touch(h.origin_id, h.oaddr, 0, 8'd0, 8'(h.hops + 8'd1), h.now);
          if (h.ttl != 8'd0) begin
            r.verdict = VERDICT_RELAY;
            r.rttl = h.ttl - 8'd1;
            r.rhops = h.hops + 8'd1;
          end else begin
            r.verdict = VERDICT_NO_RELAY;
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_verdict(verdict_rec_t got);
      verdict_rec_t exp;
      results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        $display("%0t: mismatch expected %h actual %h", $realtime, exp, got);
        if (got.verdict !== exp.verdict)
          $display("  verdict expected %0d actual %0d", exp.verdict, got.verdict);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  header_t hdr;
  logic out_valid, out_ready;
  wire verdict_rec_t res;

  relay_scoreboard sb;
  int send_idle_pct, recv_stall_pct, hold_off;
  int cycles;
  int n_items;
  logic [15:0] known_ids[8];

  flood_relay_dedup_neighbor_table dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(hdr.req_type), .in_origin_id(hdr.origin_id),
    .in_sequence_number(hdr.seq), .in_time_to_live(hdr.ttl),
    .in_hop_count(hdr.hops), .in_sender_address(hdr.saddr),
    .in_origin_address(hdr.oaddr), .in_signal_strength(hdr.sig),
    .in_time_now_ms(hdr.now), .in_slot_index(hdr.slot),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_verdict(res.verdict), .out_relay_ttl(res.rttl), .out_relay_hops(res.rhops),
    .out_slot_used(res.used), .out_slot_node_id(res.node_id),
    .out_slot_direct(res.direct), .out_slot_hops(res.hop_dist),
    .out_slot_signal(res.signal), .out_slot_last_seen(res.seen),
    .out_slot_last_direct(res.dseen), .out_slot_address(res.addr)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Result side: random stalls, plus an optional long hold-off.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_verdict(res);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OWN_ID) sb.own_id = value[15:0];
    else sb.timeout_ms = value;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Offers one transaction; idle gaps come first so valid is never dropped mid-item.
  // The block stays busy after an acceptance, so valid is dropped until the next item is offered.
  task automatic send_header(header_t h);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    hdr <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_header(h);
    in_valid <= 1'b0;
    n_items++;
    @(posedge clk);
  endtask

  function automatic header_t rand_header(logic [31:0] now);
    header_t h;
    int pick;
    h = HDR_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    h.now = now;
    pick = $urandom_range(99);
    h.req_type = (pick < 15);
    if (pick < 60) h.origin_id = known_ids[$urandom_range(7)];
    if ($urandom_range(3) == 0) h.saddr[15:0] = known_ids[$urandom_range(7)];
    if ($urandom_range(9) == 0) h.saddr[15:0] = h.origin_id;
    if ($urandom_range(4) == 0) h.seq = 16'($urandom_range(7));
    if ($urandom_range(9) == 0) h.origin_id = sb.own_id;
    return h;
  endfunction

  initial begin
    header_t h;
    logic [31:0] now;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_OWN_ID;
    cfg_data = '0;
    in_valid = 1'b0;
    hdr = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    cycles = 0;
    n_items = 0;
    for (int i = 0; i < 8; i++) known_ids[i] = 16'($urandom);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: unwritten cache pair, duplicates, extremes, own id, slot reads.
    write_reg(CFG_OWN_ID, 32'h00007777);
    h = '0;
    send_header(h);
    send_header(h);
    h.origin_id = 16'hFFFF; h.seq = 16'hFFFF; h.ttl = 8'hFF; h.hops = 8'hFF;
    h.saddr = '1; h.oaddr = '1; h.sig = 8'h80; h.now = '1;
    send_header(h);
    h.seq = 16'h0001; h.ttl = 8'd1; h.hops = 8'd3; h.saddr = 48'h1234_0000_0042;
    h.now = 32'd20000; h.sig = 8'h7F;
    send_header(h);
    h.seq = 16'h0002; h.hops = 8'd1; h.saddr = 48'hABCD_0000_FFFF;
    send_header(h);
    for (int i = 0; i < 17; i++) begin
      h = '0;
      h.req_type = 1'b1;
      h.slot = 4'(i);
      h.origin_id = 16'hFFFF;
      if (i == 16) h.slot = 4'hF;
      send_header(h);
    end
    wait_drained();
    write_reg(CFG_OWN_ID, 32'h0000FFFF);
    write_reg(CFG_TIMEOUT, 32'd0);
    h = '0; h.origin_id = 16'hFFFF; h.seq = 16'h5555;
    send_header(h);

    now = 32'd1000;
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 86; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 86; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      write_reg(CFG_OWN_ID, (ph == 7) ? 32'h0000FFFF : 32'(known_ids[ph]));
      write_reg(CFG_TIMEOUT, (ph == 6) ? 32'hFFFFFFFF : 32'($urandom_range(5000)));
      if (ph == 4) hold_off = 3000;
      for (int k = 0; k < 228; k++) begin
        now = now + 32'($urandom_range(400));
        h = rand_header(now);
        if ($urandom_range(19) == 0) h.now = $urandom;
        send_header(h);
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    $display("Ran %0d transactions (packets, duplicates, own ids, slot reads)", n_items);
    $display("over 8 phases of idling and stalling; %0d results checked", sb.results);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/frdnt_pkg.sv
hw/rtl/frdnt_dedup.sv
hw/rtl/frdnt_table.sv
hw/rtl/flood_relay_dedup_neighbor_table.sv
hw/rtl/frdnt_checker.sv
verif/tb_top.sv
